// ----- hdl/bct_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bct_pkg;

  // Default bracket stack depth
  localparam int unsigned STACK_DEPTH_DEF = 16;

  // Result queue depth, two results per source byte at most
  localparam int unsigned RES_DEPTH = 4;

  // Token kinds
  localparam logic [3:0] KIND_NONE   = 4'd0;
  localparam logic [3:0] KIND_OPEN   = 4'd1;
  localparam logic [3:0] KIND_CLOSE  = 4'd2;
  localparam logic [3:0] KIND_STRING = 4'd3;
  localparam logic [3:0] KIND_CHAR   = 4'd4;
  localparam logic [3:0] KIND_WORD   = 4'd5;
  localparam logic [3:0] KIND_INT    = 4'd6;
  localparam logic [3:0] KIND_FLOAT  = 4'd7;
  localparam logic [3:0] KIND_SYMBOL = 4'd8;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NO_OPEN   = 3'd1;
  localparam logic [2:0] ERR_MISMATCH  = 3'd2;
  localparam logic [2:0] ERR_UNCLOSED  = 3'd3;
  localparam logic [2:0] ERR_TOO_DEEP  = 3'd4;

  // Source characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_TILDE  = 8'h7E;

  // Printable range that starts a word
  localparam logic [7:0] PRINT_LO = 8'd32;
  localparam logic [7:0] PRINT_HI = 8'd126;

  // One result beat
  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] data;
    logic       data_valid;
    logic       tok_start;
    logic       tok_end;
    logic [2:0] err;
    logic       eot;
    logic       last;
  } res_t;

  // Results caused by one source byte
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } scan_out_t;

  function automatic res_t mk_res(logic [3:0] kind, logic [7:0] data, logic valid,
                                  logic start, logic stop, logic [2:0] err,
                                  logic eot);
    res_t r;
    r.kind       = kind;
    r.data       = data;
    r.data_valid = valid;
    r.tok_start  = start;
    r.tok_end    = stop;
    r.err        = err;
    r.eot        = eot;
    r.last       = 1'b0;
    return r;
  endfunction

endpackage : bct_pkg

`default_nettype wire

// ----- hdl/bct_scan.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bct_scan
  import bct_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      fire_i,
  input  wire logic [7:0] byte_i,
  output scan_out_t      out_o
);

  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // Scan modes
  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_COMMENT = 3'd1;
  localparam logic [2:0] MODE_STRING  = 3'd2;
  localparam logic [2:0] MODE_ESCAPE  = 3'd3;
  localparam logic [2:0] MODE_CHAR    = 3'd4;
  localparam logic [2:0] MODE_WORD    = 3'd5;
  localparam logic [2:0] MODE_ERROR   = 3'd6;

  // Word class flag bits
  localparam int unsigned F_SEEN  = 0;
  localparam int unsigned F_NEG   = 1;
  localparam int unsigned F_DIGIT = 2;
  localparam int unsigned F_DOT   = 3;
  localparam int unsigned F_BAD   = 4;

  logic [2:0]    mode_q, mode_d;
  logic [1:0]    quote_q, quote_d;
  logic [4:0]    flags_q, flags_d;
  logic [2:0]    err_q, err_d;
  logic [DW-1:0] depth_q, depth_d;
  logic [1:0]    tos_q;
  logic [1:0]    below_q;
  logic [1:0]    stk_mem [2**AW];

  logic          push, pop;
  logic [1:0]    push_code;
  scan_out_t     so;

  // Idle decode of the current byte
  logic          id_emit;
  res_t          id_res;
  logic [2:0]    id_mode;
  logic          id_quote_we;
  logic [1:0]    id_quote;
  logic          id_word;
  logic          id_push, id_pop;
  logic [2:0]    id_err;

  function automatic logic [4:0] word_flags(logic [4:0] f_in, logic [7:0] b);
    logic [4:0] f;
    f = f_in;
    if (!f[F_SEEN] && b == CH_MINUS) begin
      f[F_SEEN] = 1'b1;
      f[F_NEG]  = 1'b1;
    end else begin
      f[F_SEEN] = 1'b1;
      if (b >= CH_ZERO && b <= CH_NINE) begin
        f[F_DIGIT] = 1'b1;
      end else if (b == CH_DOT) begin
        if (f[F_DOT]) f[F_BAD] = 1'b1;
        else          f[F_DOT] = 1'b1;
      end else begin
        f[F_BAD] = 1'b1;
      end
    end
    return f;
  endfunction

  function automatic logic [3:0] word_kind(logic [4:0] f);
    logic [3:0] k;
    if (f[F_BAD] || !f[F_DIGIT]) k = KIND_SYMBOL;
    else if (f[F_DOT])           k = KIND_FLOAT;
    else                         k = KIND_INT;
    return k;
  endfunction

  function automatic logic is_boundary(logic [7:0] b);
    return b == CH_NUL || b == CH_SPACE || b == CH_LF || b == CH_CR || b == CH_TAB ||
           b == CH_DQUOTE || b == CH_SQUOTE || b == CH_BTICK || b == CH_LBRACK ||
           b == CH_RBRACK || b == CH_LPAREN || b == CH_RPAREN || b == CH_LBRACE ||
           b == CH_RBRACE;
  endfunction

  function automatic logic [7:0] escape_conv(logic [7:0] b);
    logic [7:0] r;
    unique case (b)
      CH_LC_T: r = CH_TAB;
      CH_LC_N: r = CH_LF;
      CH_LC_R: r = CH_CR;
      CH_LC_F: r = CH_FF;
      CH_LC_B: r = CH_BS;
      default: r = b;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] quote_char(logic [1:0] q);
    logic [7:0] c;
    unique case (q)
      2'd1:    c = CH_DQUOTE;
      2'd2:    c = CH_BTICK;
      2'd3:    c = CH_SQUOTE;
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] close_char(logic [1:0] code);
    logic [7:0] c;
    unique case (code)
      2'd1:    c = CH_RBRACK;
      2'd2:    c = CH_RBRACE;
      default: c = CH_RPAREN;
    endcase
    return c;
  endfunction

  // Decode the byte as seen from idle
  always_comb begin
    id_emit     = 1'b0;
    id_res      = mk_res(KIND_NONE, CH_NUL, 1'b0, 1'b0, 1'b0, ERR_NONE, 1'b0);
    id_mode     = MODE_IDLE;
    id_quote_we = 1'b0;
    id_quote    = 2'd0;
    id_word     = 1'b0;
    id_push     = 1'b0;
    id_pop      = 1'b0;
    id_err      = ERR_NONE;
    push_code   = 2'd0;
    unique case (byte_i) inside
      CH_HASH: begin
        id_mode = MODE_COMMENT;
      end
      CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_FF, CH_BS: begin
        id_mode = MODE_IDLE;
      end
      CH_DQUOTE, CH_BTICK, CH_SQUOTE: begin
        id_quote_we = 1'b1;
        id_quote    = (byte_i == CH_DQUOTE) ? 2'd1 : (byte_i == CH_BTICK) ? 2'd2 : 2'd3;
        id_mode     = MODE_STRING;
        id_emit     = 1'b1;
        id_res      = mk_res(KIND_STRING, CH_NUL, 1'b0, 1'b1, 1'b0, ERR_NONE, 1'b0);
      end
      CH_TILDE: begin
        id_mode = MODE_CHAR;
      end
      CH_LPAREN, CH_LBRACK, CH_LBRACE: begin
        id_emit = 1'b1;
        if (depth_q >= DW'(STACK_DEPTH)) begin
          id_err  = ERR_TOO_DEEP;
          id_mode = MODE_ERROR;
          id_res  = mk_res(KIND_NONE, byte_i, 1'b0, 1'b0, 1'b0, ERR_TOO_DEEP, 1'b0);
        end else begin
          id_push   = 1'b1;
          push_code = (byte_i == CH_LPAREN) ? 2'd0 : (byte_i == CH_LBRACK) ? 2'd1 : 2'd2;
          id_res    = mk_res(KIND_OPEN, byte_i, 1'b1, 1'b1, 1'b1, ERR_NONE, 1'b0);
        end
      end
      CH_RPAREN, CH_RBRACK, CH_RBRACE: begin
        id_emit = 1'b1;
        if (depth_q == '0) begin
          id_err  = ERR_NO_OPEN;
          id_mode = MODE_ERROR;
          id_res  = mk_res(KIND_NONE, byte_i, 1'b0, 1'b0, 1'b0, ERR_NO_OPEN, 1'b0);
        end else if (close_char(tos_q) != byte_i) begin
          id_err  = ERR_MISMATCH;
          id_mode = MODE_ERROR;
          id_res  = mk_res(KIND_NONE, byte_i, 1'b0, 1'b0, 1'b0, ERR_MISMATCH, 1'b0);
        end else begin
          id_pop = 1'b1;
          id_res = mk_res(KIND_CLOSE, byte_i, 1'b1, 1'b1, 1'b1, ERR_NONE, 1'b0);
        end
      end
      default: begin
        if (byte_i >= PRINT_LO && byte_i <= PRINT_HI) begin
          id_word = 1'b1;
          id_mode = MODE_WORD;
          id_emit = 1'b1;
          id_res  = mk_res(KIND_WORD, byte_i, 1'b1, 1'b1, 1'b0, ERR_NONE, 1'b0);
        end
      end
    endcase
  end

  // Step the scanner for one byte
  always_comb begin
    mode_d  = mode_q;
    quote_d = quote_q;
    flags_d = flags_q;
    err_d   = err_q;
    depth_d = depth_q;
    push    = 1'b0;
    pop     = 1'b0;
    so.cnt  = 2'd0;
    so.r0   = mk_res(KIND_NONE, CH_NUL, 1'b0, 1'b0, 1'b0, ERR_NONE, 1'b0);
    so.r1   = so.r0;

    if (byte_i == CH_NUL) begin
      // End of text: close open token, report, then clear
      if (mode_q == MODE_WORD || mode_q == MODE_STRING || mode_q == MODE_ESCAPE) begin
        so.cnt = 2'd2;
        so.r0  = mk_res((mode_q == MODE_WORD) ? word_kind(flags_q) : KIND_STRING,
                        CH_NUL, 1'b0, 1'b0, 1'b1, ERR_NONE, 1'b0);
        so.r1  = mk_res(KIND_NONE, CH_NUL, 1'b0, 1'b0, 1'b0,
                        (err_q != ERR_NONE) ? err_q :
                        (depth_q != '0) ? ERR_UNCLOSED : ERR_NONE, 1'b1);
      end else begin
        so.cnt = 2'd1;
        so.r0  = mk_res(KIND_NONE, CH_NUL, 1'b0, 1'b0, 1'b0,
                        (err_q != ERR_NONE) ? err_q :
                        (depth_q != '0) ? ERR_UNCLOSED : ERR_NONE, 1'b1);
      end
      mode_d  = MODE_IDLE;
      quote_d = 2'd0;
      flags_d = '0;
      err_d   = ERR_NONE;
      depth_d = '0;
    end else begin
      unique case (mode_q)
        MODE_ERROR: begin
          mode_d = MODE_ERROR;
        end
        MODE_COMMENT: begin
          if (byte_i == CH_LF) mode_d = MODE_IDLE;
        end
        MODE_STRING: begin
          if (byte_i == CH_BSLASH) begin
            mode_d = MODE_ESCAPE;
          end else if (byte_i == quote_char(quote_q)) begin
            so.cnt = 2'd1;
            so.r0  = mk_res(KIND_STRING, CH_NUL, 1'b0, 1'b0, 1'b1, ERR_NONE, 1'b0);
            mode_d = MODE_IDLE;
          end else begin
            so.cnt = 2'd1;
            so.r0  = mk_res(KIND_STRING, byte_i, 1'b1, 1'b0, 1'b0, ERR_NONE, 1'b0);
          end
        end
        MODE_ESCAPE: begin
          so.cnt = 2'd1;
          so.r0  = mk_res(KIND_STRING, escape_conv(byte_i), 1'b1, 1'b0, 1'b0,
                          ERR_NONE, 1'b0);
          mode_d = MODE_STRING;
        end
        MODE_CHAR: begin
          so.cnt = 2'd1;
          so.r0  = mk_res(KIND_CHAR, byte_i, 1'b1, 1'b1, 1'b1, ERR_NONE, 1'b0);
          mode_d = MODE_IDLE;
        end
        MODE_WORD: begin
          if (!is_boundary(byte_i)) begin
            flags_d = word_flags(flags_q, byte_i);
            so.cnt  = 2'd1;
            so.r0   = mk_res(KIND_WORD, byte_i, 1'b1, 1'b0, 1'b0, ERR_NONE, 1'b0);
          end else begin
            // End the word, then treat the boundary byte as in idle
            so.r0   = mk_res(word_kind(flags_q), CH_NUL, 1'b0, 1'b0, 1'b1, ERR_NONE, 1'b0);
            so.r1   = id_res;
            so.cnt  = id_emit ? 2'd2 : 2'd1;
            flags_d = '0;
            mode_d  = id_mode;
            if (id_quote_we) quote_d = id_quote;
            if (id_err != ERR_NONE) err_d = id_err;
            push = id_push;
            pop  = id_pop;
          end
        end
        default: begin
          so.r0  = id_res;
          so.cnt = id_emit ? 2'd1 : 2'd0;
          mode_d = id_mode;
          if (id_quote_we) quote_d = id_quote;
          if (id_word) flags_d = word_flags(5'd0, byte_i);
          if (id_err != ERR_NONE) err_d = id_err;
          push = id_push;
          pop  = id_pop;
        end
      endcase
      if (push) depth_d = depth_q + DW'(1);
      if (pop)  depth_d = depth_q - DW'(1);
    end

    // Mark the final result of this byte
    if (so.cnt == 2'd1) so.r0.last = 1'b1;
    if (so.cnt == 2'd2) so.r1.last = 1'b1;
  end

  assign out_o = so;

  // Hold scanner state between beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      quote_q <= 2'd0;
      flags_q <= '0;
      err_q   <= ERR_NONE;
      depth_q <= '0;
    end else if (fire_i) begin
      mode_q  <= mode_d;
      quote_q <= quote_d;
      flags_q <= flags_d;
      err_q   <= err_d;
      depth_q <= depth_d;
    end
  end

  // Bracket stack: top and next entry in registers, the rest in memory
  always_ff @(posedge clk_i) begin
    if (fire_i && push) begin
      if (depth_q != '0) stk_mem[AW'(depth_q - DW'(1))] <= tos_q;
      tos_q   <= push_code;
      below_q <= tos_q;
    end else if (fire_i && pop) begin
      tos_q   <= below_q;
      below_q <= stk_mem[AW'(depth_q - DW'(3))];
    end
  end

  // Depth stays within the stack
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(STACK_DEPTH))
    else $error("bracket depth beyond stack size");

  // End of text returns the scanner to idle with an empty stack
  a_eot_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && byte_i == CH_NUL |=> mode_q == MODE_IDLE && depth_q == '0 && err_q == ERR_NONE)
    else $error("end of text did not clear scanner");

  // Two results only come with the last mark on the second one
  a_last_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.cnt == 2'd2 |-> out_o.r1.last && !out_o.r0.last)
    else $error("last mark misplaced");

  // Error mode always carries a latched code
  a_err_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_ERROR |-> err_q != ERR_NONE)
    else $error("error mode without code");

endmodule : bct_scan

`default_nettype wire

// ----- hdl/bct_res_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bct_res_fifo
  import bct_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire scan_out_t in_i,
  input  wire logic      pop_i,
  output logic           space_o,
  output logic           valid_o,
  output res_t           head_o
);

  localparam int unsigned PW = $clog2(RES_DEPTH);
  localparam int unsigned CW = $clog2(RES_DEPTH + 1);

  res_t          mem_q [RES_DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] wr_cnt;
  logic          rd;

  assign wr_cnt  = push_i ? CW'(in_i.cnt) : '0;
  assign rd      = pop_i && valid_o;
  assign valid_o = count_q != '0;
  assign space_o = count_q <= CW'(RES_DEPTH - 2);
  assign head_o  = mem_q[rp_q];

  // Store up to two results per beat
  always_ff @(posedge clk_i) begin
    if (wr_cnt != '0) mem_q[wp_q] <= in_i.r0;
    if (wr_cnt == CW'(2)) mem_q[wp_q + PW'(1)] <= in_i.r1;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else begin
      wp_q    <= wp_q + PW'(wr_cnt);
      rp_q    <= rp_q + PW'(rd);
      count_q <= count_q + wr_cnt - CW'(rd);
    end
  end

  // Occupancy never exceeds the queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(RES_DEPTH))
    else $error("result queue overflow");

  // Writes only land where there is room
  a_write_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_cnt != '0 |-> count_q + wr_cnt <= CW'(RES_DEPTH))
    else $error("result queue written while full");

  // Pointers stay apart by the occupancy
  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    PW'(wp_q - rp_q) == PW'(count_q))
    else $error("result queue pointers out of step");

endmodule : bct_res_fifo

`default_nettype wire

// ----- hdl/bracket_checking_tokenizer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Bracket-checking tokenizer: scans source text one byte per beat.
// Input stream: s_axis carries one source byte in tdata[7:0]; a zero byte
// ends the text, reports the result and returns the scanner to idle.
// Output stream: m_axis carries one result per beat. tuser holds the token
// kind, tdata the byte, flags and error code, tlast marks the final result
// caused by a source byte. A byte causes zero, one or two results.
// The input register holds an accepted byte until the result queue has room;
// its results are then written into the queue, from whose head they are
// presented on m_axis.
// Throughput: one byte per cycle while each byte yields at most one result
// and m_axis does not stall; output bandwidth is set by the single output
// port draining the four-entry result queue.
// A byte is taken from the input register only when the queue has room for
// two results, so a stall at m_axis backs up into s_axis tready after the
// queue fills; no result is lost or repeated.
// Reset clears the scan mode, nesting depth, word flags, error latch and
// the result queue; bracket stack contents are not cleared.
module bracket_checking_tokenizer
  import bct_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] data_byte, [8] data_valid,
                                           // [9] token_start, [10] token_end,
                                           // [13:11] error_code, [14] end_of_text
  output logic [3:0]       m_axis_tuser,   // [3:0] token_kind
  output logic             m_axis_tlast
);

  logic      in_valid_q;
  logic [7:0] in_byte_q;
  logic      fire;
  logic      space;
  scan_out_t scan_out;
  res_t      head;

  assign fire          = in_valid_q && space;
  assign s_axis_tready = !in_valid_q || fire;

  // Hold the accepted byte until the queue has room
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) in_byte_q <= s_axis_tdata;
  end

  bct_scan #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_scan (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(fire),
    .byte_i(in_byte_q),
    .out_o (scan_out)
  );

  bct_res_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fire),
    .in_i   (scan_out),
    .pop_i  (m_axis_tready),
    .space_o(space),
    .valid_o(m_axis_tvalid),
    .head_o (head)
  );

  // Pack the head result onto the output beat
  assign m_axis_tdata = {1'b0, head.eot, head.err, head.tok_end, head.tok_start,
                         head.data_valid, head.data};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule : bracket_checking_tokenizer

`default_nettype wire

// ----- test/tb_bracket_checking_tokenizer.sv -----
`timescale 1ns / 1ps

module tb_bracket_checking_tokenizer;
  import bct_pkg::*;

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_COMMENT,
    SCAN_STRING,
    SCAN_ESCAPE,
    SCAN_CHAR,
    SCAN_WORD,
    SCAN_ERROR
  } scan_state_e;

  // Word shape flags
  localparam logic [5:0] WF_SEEN  = 6'd1;
  localparam logic [5:0] WF_NEG   = 6'd2;
  localparam logic [5:0] WF_DIGIT = 6'd4;
  localparam logic [5:0] WF_DOT   = 6'd8;
  localparam logic [5:0] WF_BAD   = 6'd16;

  localparam int unsigned RANDOM_BYTES = 1200;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // Scanner state as predicted
  scan_state_e scan_st;
  logic [7:0]  quote_ch;
  logic [7:0]  close_stack [STACK_DEPTH_DEF];
  int unsigned nest_lvl;
  logic [5:0]  word_bits;
  logic [2:0]  err_held;

  // Source bytes waiting to be sent: [8] waits for all results, [7:0] byte
  logic [8:0]  src_q [$];
  res_t        token_beats [$];
  bit          drain_next = 1'b0;
  int unsigned bytes_taken = 0;
  int unsigned mismatches = 0;
  logic [8:0]  nxt;
  res_t        want_beat;
  logic        calm;

  always #4 clk_i = ~clk_i;

  bracket_checking_tokenizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // No random idling on either side through this stretch of the run
  assign calm = (bytes_taken >= 400) && (bytes_taken < 800);

  function automatic bit ends_word(logic [7:0] b);
    return b inside {CH_NUL, CH_SPACE, CH_LF, CH_CR, CH_TAB, CH_DQUOTE, CH_SQUOTE,
                     CH_BTICK, CH_LBRACK, CH_RBRACK, CH_LPAREN, CH_RPAREN,
                     CH_LBRACE, CH_RBRACE};
  endfunction

  function automatic logic [5:0] next_word_bits(logic [5:0] f, logic [7:0] b);
    logic [5:0] n;
    n = f | WF_SEEN;
    if ((f & WF_SEEN) == 6'd0 && b == CH_MINUS) n = n | WF_NEG;
    else if (b >= CH_ZERO && b <= CH_NINE) n = n | WF_DIGIT;
    else if (b == CH_DOT) n = n | (((f & WF_DOT) != 6'd0) ? WF_BAD : WF_DOT);
    else n = n | WF_BAD;
    return n;
  endfunction

  function automatic logic [3:0] word_kind(logic [5:0] f);
    if ((f & WF_BAD) != 6'd0 || (f & WF_DIGIT) == 6'd0) return KIND_SYMBOL;
    return ((f & WF_DOT) != 6'd0) ? KIND_FLOAT : KIND_INT;
  endfunction

  function automatic logic [7:0] unescape(logic [7:0] b);
    case (b)
      CH_LC_T: return CH_TAB;
      CH_LC_N: return CH_LF;
      CH_LC_R: return CH_CR;
      CH_LC_F: return CH_FF;
      CH_LC_B: return CH_BS;
      default: return b;
    endcase
  endfunction

  function automatic logic [7:0] closer_of(logic [7:0] b);
    case (b)
      CH_LPAREN: return CH_RPAREN;
      CH_LBRACK: return CH_RBRACK;
      default:   return CH_RBRACE;
    endcase
  endfunction

  task automatic clear_scanner();
    scan_st   = SCAN_IDLE;
    quote_ch  = 8'h00;
    nest_lvl  = 0;
    word_bits = 6'd0;
    err_held  = ERR_NONE;
  endtask

  task automatic add_beat(logic [3:0] kind, logic [7:0] data, logic valid, logic start,
                          logic stop, logic [2:0] err, logic eot);
    res_t r;
    r.kind       = kind;
    r.data       = data;
    r.data_valid = valid;
    r.tok_start  = start;
    r.tok_end    = stop;
    r.err        = err;
    r.eot        = eot;
    r.last       = 1'b0;
    token_beats.push_back(r);
  endtask

  task automatic raise_error(logic [7:0] b, logic [2:0] code);
    err_held = code;
    scan_st  = SCAN_ERROR;
    add_beat(KIND_NONE, b, 1'b0, 1'b0, 1'b0, code, 1'b0);
  endtask

  // Work out the result beats that one accepted source byte causes
  task automatic tokenize_byte(logic [7:0] b);
    int unsigned held_before;
    bit          from_idle;
    logic [2:0]  code;
    res_t        tail;
    held_before = token_beats.size();
    from_idle   = 1'b0;
    if (b == CH_NUL) begin
      if (scan_st == SCAN_WORD)
        add_beat(word_kind(word_bits), 8'h00, 1'b0, 1'b0, 1'b1, ERR_NONE, 1'b0);
      else if (scan_st == SCAN_STRING || scan_st == SCAN_ESCAPE)
        add_beat(KIND_STRING, 8'h00, 1'b0, 1'b0, 1'b1, ERR_NONE, 1'b0);
      code = (err_held != ERR_NONE) ? err_held : ((nest_lvl != 0) ? ERR_UNCLOSED : ERR_NONE);
      add_beat(KIND_NONE, 8'h00, 1'b0, 1'b0, 1'b0, code, 1'b1);
      clear_scanner();
    end else begin
      case (scan_st)
        SCAN_ERROR: ;
        SCAN_COMMENT: if (b == CH_LF) scan_st = SCAN_IDLE;
        SCAN_STRING: begin
          if (b == CH_BSLASH) begin
            scan_st = SCAN_ESCAPE;
          end else if (b == quote_ch) begin
            add_beat(KIND_STRING, 8'h00, 1'b0, 1'b0, 1'b1, ERR_NONE, 1'b0);
            scan_st = SCAN_IDLE;
          end else begin
            add_beat(KIND_STRING, b, 1'b1, 1'b0, 1'b0, ERR_NONE, 1'b0);
          end
        end
        SCAN_ESCAPE: begin
          add_beat(KIND_STRING, unescape(b), 1'b1, 1'b0, 1'b0, ERR_NONE, 1'b0);
          scan_st = SCAN_STRING;
        end
        SCAN_CHAR: begin
          add_beat(KIND_CHAR, b, 1'b1, 1'b1, 1'b1, ERR_NONE, 1'b0);
          scan_st = SCAN_IDLE;
        end
        SCAN_WORD: begin
          if (!ends_word(b)) begin
            word_bits = next_word_bits(word_bits, b);
            add_beat(KIND_WORD, b, 1'b1, 1'b0, 1'b0, ERR_NONE, 1'b0);
          end else begin
            // Close the word, then treat the boundary byte as in idle
            add_beat(word_kind(word_bits), 8'h00, 1'b0, 1'b0, 1'b1, ERR_NONE, 1'b0);
            word_bits = 6'd0;
            from_idle = 1'b1;
          end
        end
        default: from_idle = 1'b1;
      endcase
      if (from_idle) begin
        scan_st = SCAN_IDLE;
        case (b)
          CH_HASH: scan_st = SCAN_COMMENT;
          CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_FF, CH_BS: ;
          CH_DQUOTE, CH_BTICK, CH_SQUOTE: begin
            quote_ch = b;
            scan_st  = SCAN_STRING;
            add_beat(KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b0, ERR_NONE, 1'b0);
          end
          CH_TILDE: scan_st = SCAN_CHAR;
          CH_LPAREN, CH_LBRACK, CH_LBRACE: begin
            if (nest_lvl >= STACK_DEPTH_DEF) begin
              raise_error(b, ERR_TOO_DEEP);
            end else begin
              close_stack[nest_lvl] = closer_of(b);
              nest_lvl++;
              add_beat(KIND_OPEN, b, 1'b1, 1'b1, 1'b1, ERR_NONE, 1'b0);
            end
          end
          CH_RPAREN, CH_RBRACK, CH_RBRACE: begin
            if (nest_lvl == 0) begin
              raise_error(b, ERR_NO_OPEN);
            end else begin
              nest_lvl--;
              if (close_stack[nest_lvl] != b) raise_error(b, ERR_MISMATCH);
              else add_beat(KIND_CLOSE, b, 1'b1, 1'b1, 1'b1, ERR_NONE, 1'b0);
            end
          end
          default: begin
            if (b >= PRINT_LO && b <= PRINT_HI) begin
              word_bits = next_word_bits(6'd0, b);
              scan_st   = SCAN_WORD;
              add_beat(KIND_WORD, b, 1'b1, 1'b1, 1'b0, ERR_NONE, 1'b0);
            end
          end
        endcase
      end
    end
    // Mark the final beat of this byte
    if (token_beats.size() > held_before) begin
      tail = token_beats.pop_back();
      tail.last = 1'b1;
      token_beats.push_back(tail);
    end
  endtask

  // Source text builders
  task automatic put(logic [7:0] b);
    src_q.push_back({drain_next, b});
    drain_next = 1'b0;
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  task automatic put_digits(int unsigned lo, int unsigned hi);
    repeat ($urandom_range(hi, lo)) put(CH_ZERO + 8'($urandom_range(9)));
  endtask

  task automatic put_gap();
    case ($urandom_range(5))
      0: put(CH_TAB);
      1: put(CH_LF);
      2: put(CH_CR);
      3: put(CH_FF);
      4: put(CH_BS);
      default: put(CH_SPACE);
    endcase
  endtask

  task automatic rand_word();
    int unsigned shape;
    logic [7:0]  b;
    shape = $urandom_range(6);
    if (shape < 4 && $urandom_range(2) == 0) put(CH_MINUS);
    case (shape)
      0, 1: put_digits(1, 6);
      2: begin
        put_digits(0, 3);
        put(CH_DOT);
        put_digits(1, 3);
      end
      3: begin
        put_digits(1, 3);
        put(CH_DOT);
      end
      4, 5: begin
        do b = 8'($urandom_range(126, 33));
        while (ends_word(b) || b == CH_HASH || b == CH_TILDE);
        put(b);
        repeat ($urandom_range(6)) begin
          do b = 8'($urandom_range(255, 1));
          while (ends_word(b));
          put(b);
        end
      end
      default: begin
        // Doubled minus, stray dots or a lone minus
        case ($urandom_range(2))
          0: begin
            put(CH_MINUS);
            put(CH_MINUS);
            put_digits(0, 3);
          end
          1: begin
            put_digits(1, 2);
            put(CH_DOT);
            put_digits(0, 2);
            put(CH_DOT);
            put_digits(0, 2);
          end
          default: put(CH_MINUS);
        endcase
      end
    endcase
  endtask

  task automatic rand_string();
    logic [7:0] q;
    logic [7:0] b;
    case ($urandom_range(2))
      0: q = CH_DQUOTE;
      1: q = CH_BTICK;
      default: q = CH_SQUOTE;
    endcase
    put(q);
    repeat ($urandom_range(8)) begin
      if ($urandom_range(4) == 0) begin
        put(CH_BSLASH);
        case ($urandom_range(6))
          0: put(CH_LC_T);
          1: put(CH_LC_N);
          2: put(CH_LC_R);
          3: put(CH_LC_F);
          4: put(CH_LC_B);
          default: put(8'($urandom_range(255, 1)));
        endcase
      end else begin
        do b = 8'($urandom_range(255, 1));
        while (b == q || b == CH_BSLASH);
        put(b);
      end
    end
    put(q);
  endtask

  task automatic rand_comment();
    logic [7:0] b;
    put(CH_HASH);
    repeat ($urandom_range(6)) begin
      do b = 8'($urandom_range(255, 1));
      while (b == CH_LF);
      put(b);
    end
    put(CH_LF);
  endtask

  task automatic rand_open(ref logic [7:0] closers[$]);
    logic [7:0] b;
    case ($urandom_range(2))
      0: b = CH_LPAREN;
      1: b = CH_LBRACK;
      default: b = CH_LBRACE;
    endcase
    put(b);
    closers.push_back(closer_of(b));
  endtask

  // One text: mostly well-formed token runs, some noise and broken nesting
  task automatic rand_text();
    int unsigned flavor;
    int unsigned pick;
    logic [7:0]  closers[$];
    flavor = $urandom_range(99);
    if (flavor < 8) begin
      repeat ($urandom_range(24, 1)) put(8'($urandom_range(255, 1)));
    end else if (flavor < 12) begin
      // Fill the stack, sometimes one past it
      repeat (STACK_DEPTH_DEF) rand_open(closers);
      if ($urandom_range(1) == 0) rand_open(closers);
      rand_word();
      while (closers.size() != 0) put(closers.pop_back());
    end else begin
      repeat ($urandom_range(20, 3)) begin
        pick = $urandom_range(99);
        if (pick < 18 && closers.size() < STACK_DEPTH_DEF) begin
          rand_open(closers);
        end else if (pick < 34 && closers.size() != 0) begin
          put(closers.pop_back());
        end else if (pick < 58) begin
          rand_word();
          if ($urandom_range(9) < 7) put_gap();
        end else if (pick < 72) begin
          rand_string();
        end else if (pick < 80) begin
          put(CH_TILDE);
          put(8'($urandom_range(255, 1)));
        end else if (pick < 86) begin
          rand_comment();
        end else begin
          put_gap();
        end
      end
      if (flavor < 22) begin
        // Broken nesting: stray or wrong close, then more tokens
        case ($urandom_range(2))
          0: put(CH_RPAREN);
          1: put(CH_RBRACK);
          default: put(CH_RBRACE);
        endcase
        rand_word();
      end else if (flavor < 90) begin
        while (closers.size() != 0) put(closers.pop_back());
      end
    end
    put(CH_NUL);
  endtask

  // Accept source bytes, predict their results, offer the next byte
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        tokenize_byte(s_axis_tdata);
        bytes_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_q.size() != 0 && !(src_q[0][8] && token_beats.size() != 0) &&
            (calm || $urandom_range(99) >= 6)) begin
          nxt = src_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= nxt[7:0];
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      mismatches++;
    end
  endtask

  // Check each result beat against the oldest expectation
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 6);
      if (m_axis_tvalid && m_axis_tready) begin
        if (token_beats.size() == 0) begin
          $error("result beat with none expected: tuser %0d tdata %h", m_axis_tuser,
                 m_axis_tdata);
          mismatches++;
        end else begin
          want_beat = token_beats.pop_front();
          check_field("token_kind", want_beat.kind, m_axis_tuser);
          check_field("data_byte", want_beat.data, m_axis_tdata[7:0]);
          check_field("data_valid", want_beat.data_valid, m_axis_tdata[8]);
          check_field("token_start", want_beat.tok_start, m_axis_tdata[9]);
          check_field("token_end", want_beat.tok_end, m_axis_tdata[10]);
          check_field("error_code", want_beat.err, m_axis_tdata[13:11]);
          check_field("end_of_text", want_beat.eot, m_axis_tdata[14]);
          check_field("last", want_beat.last, m_axis_tlast);
        end
      end
    end
  end

  initial begin
    int unsigned random_from;
    clear_scanner();

    // Number classes, doubled minus, lone minus, brackets of each kind
    put_text("([{-42 3.14 5. .5 1.2.3 --7 -}])");
    put(CH_NUL);
    // Odd bytes inside a word, word ended by quote and by bracket
    put_text("x#~");
    put(8'hFF);
    put(CH_FF);
    put(CH_BS);
    put_text("y(z)ab\"c\\t\\n\\r\\f\\b\\q\\\\\\\"\"`'\"`'k'");
    put(CH_NUL);
    // Char tokens, comment, ignored whitespace and control bytes
    put_text("~a~~~");
    put(8'h80);
    put_text("# note ) ]\n");
    put(CH_TAB);
    put(CH_CR);
    put(8'h01);
    put(8'h7F);
    put(8'hC3);
    put(CH_NUL);
    // Close without open; later bytes ignored
    put_text(") abc");
    put(CH_NUL);
    // Wrong close
    put_text("(]x");
    put(CH_NUL);
    // Nesting one past the stack
    repeat (STACK_DEPTH_DEF + 1) put(CH_LBRACE);
    put(CH_NUL);
    // Unclosed at end, and the end byte inside a string, escape or char
    put_text("[x");
    put(CH_NUL);
    put_text("\"ab");
    put(CH_NUL);
    put_text("'\\");
    put(CH_NUL);
    put(CH_TILDE);
    put(CH_NUL);
    put(CH_NUL);

    random_from = src_q.size();
    drain_next = 1'b1;
    while (src_q.size() < random_from + RANDOM_BYTES) begin
      rand_text();
      drain_next = ($urandom_range(9) == 0);
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (src_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (token_beats.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
